@@ src/burst_fire_zero_cross_power_control_top_defines.svh @@
// Assertion macros for the checker file of the burst-fire power controller.
// No dependencies; include by bare file name where assertions are written.
`ifndef BURST_FIRE_ZERO_CROSS_POWER_CONTROL_TOP_DEFINES_SVH
`define BURST_FIRE_ZERO_CROSS_POWER_CONTROL_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset
`define BFZC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset
`define BFZC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/bfzc_pkg.sv @@
// Shared constants, register codes and controller/datapath interface types
// for the burst-fire power controller. No dependencies.
package bfzc_pkg;

    // Frame and power setting
    localparam int FRAME_SIZE   = 100;
    localparam int FRAME_W      = 8;
    localparam int PWR_W        = 8;
    localparam int PCT_SCALE    = 100;

    // Percent scaling by reciprocal multiply: floor(p*FRAME_SIZE/100) comes out
    // exact for every 8-bit p at this shift
    localparam int PCT_RECIP_SH = 24;
    localparam int PCT_RECIP    = (2**PCT_RECIP_SH + PCT_SCALE - 1) / PCT_SCALE;
    localparam int PCT_MUL      = FRAME_SIZE * PCT_RECIP;
    localparam int PCT_PROD_W   = PWR_W + 26;
    localparam int PCT_Q_W      = PCT_PROD_W - PCT_RECIP_SH;

    // Indicator divider
    localparam int LED_DIVISOR  = 60;
    localparam int LED_CNT_W    = 6;

    // Frequency measurement
    localparam int WC_W         = 16;
    localparam int PERIOD_W     = 16;
    localparam int PERIOD_RESET = 1000;
    localparam int MS_PER_S     = 1000;
    localparam int MS_PER_S_W   = 10;
    localparam int FREQ_W       = 10;
    localparam int FREQ_MAX     = 1023;

    // Divider geometry
    localparam int DVD_W        = WC_W + MS_PER_S_W;
    localparam int DSR_W        = PERIOD_W;
    localparam int DIV_CNT_W    = $clog2(DVD_W + 1);

    // Configuration port
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // Stream payload layout
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 32;
    localparam int M_FIELDS_W   = 3 + FREQ_W + WC_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEATER_EN = 2'd0,
        CFG_POWER_RAW = 2'd1,
        CFG_POWER_VAL = 2'd2,
        CFG_PERIOD    = 2'd3
    } cfg_idx_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic cross_step;
        logic tgt_load;
        logic frame_step;
        logic freq_start;
        logic freq_load;
        logic window_dec;
        logic out_load;
    } bfzc_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic crossing;
        logic tick;
        logic frame_wrap;
        logic window_end;
        logic div_done;
        logic out_free;
    } bfzc_sts_t;

endpackage

@@ src/bfzc_div.sv @@
// Restoring divider, one quotient bit per cycle, used for the frequency
// measurement (crossings*1000/period). Depends on bfzc_pkg.
module bfzc_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [bfzc_pkg::DVD_W-1:0]  dividend,
    input  logic [bfzc_pkg::DSR_W-1:0]  divisor,
    output logic                        done,
    output logic [bfzc_pkg::DVD_W-1:0]  quotient
);

    logic [bfzc_pkg::DVD_W-1:0]     dvd_reg;
    logic [bfzc_pkg::DSR_W:0]       rem_reg;
    logic [bfzc_pkg::DSR_W-1:0]     dsr_reg;
    logic [bfzc_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [bfzc_pkg::DSR_W:0]       rem_shift;
    logic                           rem_ge;
    logic [bfzc_pkg::DSR_W:0]       rem_next;
    logic [bfzc_pkg::DVD_W-1:0]     dvd_next;

    // Shift in the next dividend bit and try one subtract
    always_comb begin
        rem_shift = {rem_reg[bfzc_pkg::DSR_W-1:0], dvd_reg[bfzc_pkg::DVD_W-1]};
        rem_ge    = rem_shift >= {1'b0, dsr_reg};
        rem_next  = rem_ge ? (rem_shift - {1'b0, dsr_reg}) : rem_shift;
        dvd_next  = {dvd_reg[bfzc_pkg::DVD_W-2:0], rem_ge};
    end

    // Control: count steps, pulse done after the last one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= bfzc_pkg::DIV_CNT_W'(bfzc_pkg::DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == bfzc_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands and partial remainder
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

@@ src/bfzc_dp.sv @@
// Datapath: configuration registers, frame and window counters, output
// register and the frequency divider. Depends on bfzc_pkg and bfzc_div.
module bfzc_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [bfzc_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [bfzc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input item fields
    input  logic                                zero_pin,
    input  logic                                ms_tick,
    // result beat
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bfzc_pkg::M_TDATA_W-1:0]      m_tdata,
    // controller link
    input  bfzc_pkg::bfzc_cmd_t                 cmd,
    output bfzc_pkg::bfzc_sts_t                 sts
);

    localparam logic [bfzc_pkg::FRAME_W-1:0] FRAME_LAST =
        bfzc_pkg::FRAME_W'(bfzc_pkg::FRAME_SIZE - 1);
    localparam logic [bfzc_pkg::FRAME_W-1:0] FRAME_FULL =
        bfzc_pkg::FRAME_W'(bfzc_pkg::FRAME_SIZE);
    localparam logic [bfzc_pkg::LED_CNT_W-1:0] LED_LAST =
        bfzc_pkg::LED_CNT_W'(bfzc_pkg::LED_DIVISOR - 1);

    // Configuration registers
    logic                               heater_en_reg;
    logic                               power_raw_reg;
    logic [bfzc_pkg::PWR_W-1:0]         power_val_reg;
    logic [bfzc_pkg::PERIOD_W-1:0]      period_reg;

    // Item and control state
    logic                               prev_pin_reg;
    logic                               crossing_reg;
    logic                               tick_reg;
    logic [bfzc_pkg::FRAME_W-1:0]       fp_reg;
    logic [bfzc_pkg::FRAME_W-1:0]       fires_reg;
    logic [bfzc_pkg::FRAME_W-1:0]       skips_reg;
    logic                               drive_reg;
    logic                               led_reg;
    logic [bfzc_pkg::LED_CNT_W-1:0]     led_cnt_reg;
    logic [bfzc_pkg::WC_W-1:0]          wc_reg;
    logic [bfzc_pkg::PERIOD_W-1:0]      mte_reg;
    logic [bfzc_pkg::FREQ_W-1:0]        freq_reg;
    logic                               m_tvalid_reg;
    logic [bfzc_pkg::M_TDATA_W-1:0]     m_tdata_reg;

    // Combinational values
    logic [bfzc_pkg::FRAME_W-1:0]       fp_next;
    logic [bfzc_pkg::LED_CNT_W-1:0]     led_cnt_next;
    logic [bfzc_pkg::PERIOD_W-1:0]      period_eff;
    logic [bfzc_pkg::PCT_PROD_W-1:0]    pct_prod;
    logic [bfzc_pkg::PCT_Q_W-1:0]       pct_q;
    logic [bfzc_pkg::PCT_Q_W-1:0]       tgt_src;
    logic [bfzc_pkg::FRAME_W-1:0]       tgt_next;
    logic [bfzc_pkg::FREQ_W-1:0]        freq_next;
    logic [bfzc_pkg::DVD_W-1:0]         div_dvd;
    logic [bfzc_pkg::DSR_W-1:0]         div_dsr;
    logic                               div_done;
    logic [bfzc_pkg::DVD_W-1:0]         div_q;

    // Frame position, indicator phase, fire target and clamped frequency
    always_comb begin
        fp_next      = (fp_reg == FRAME_LAST) ? '0 : fp_reg + 1'b1;
        led_cnt_next = (led_cnt_reg == LED_LAST) ? '0 : led_cnt_reg + 1'b1;
        period_eff   = (period_reg == '0) ? bfzc_pkg::PERIOD_W'(1) : period_reg;
        pct_prod     = bfzc_pkg::PCT_PROD_W'(power_val_reg)
                       * bfzc_pkg::PCT_PROD_W'(bfzc_pkg::PCT_MUL);
        pct_q        = pct_prod[bfzc_pkg::PCT_PROD_W-1:bfzc_pkg::PCT_RECIP_SH];
        tgt_src      = power_raw_reg ? bfzc_pkg::PCT_Q_W'(power_val_reg) : pct_q;
        tgt_next     = (tgt_src > bfzc_pkg::PCT_Q_W'(bfzc_pkg::FRAME_SIZE))
                       ? FRAME_FULL : tgt_src[bfzc_pkg::FRAME_W-1:0];
        freq_next    = (div_q > bfzc_pkg::DVD_W'(bfzc_pkg::FREQ_MAX))
                       ? bfzc_pkg::FREQ_W'(bfzc_pkg::FREQ_MAX) : div_q[bfzc_pkg::FREQ_W-1:0];
    end

    // Divider operands: crossings*1000/period
    always_comb begin
        div_dvd = bfzc_pkg::DVD_W'(wc_reg) * bfzc_pkg::DVD_W'(bfzc_pkg::MS_PER_S);
        div_dsr = period_eff;
    end

    bfzc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.freq_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    // Take configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heater_en_reg <= 1'b0;
            power_raw_reg <= 1'b0;
            power_val_reg <= '0;
            period_reg    <= bfzc_pkg::PERIOD_W'(bfzc_pkg::PERIOD_RESET);
        end else if (cfg_we) begin
            unique case (bfzc_pkg::cfg_idx_t'(cfg_idx))
                bfzc_pkg::CFG_HEATER_EN: heater_en_reg <= cfg_wdata[0];
                bfzc_pkg::CFG_POWER_RAW: power_raw_reg <= cfg_wdata[0];
                bfzc_pkg::CFG_POWER_VAL: power_val_reg <= cfg_wdata[bfzc_pkg::PWR_W-1:0];
                bfzc_pkg::CFG_PERIOD:    period_reg    <= cfg_wdata[bfzc_pkg::PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // Edge detect, frame counters, window counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pin_reg <= 1'b0;
            crossing_reg <= 1'b0;
            tick_reg     <= 1'b0;
            fp_reg       <= '0;
            fires_reg    <= '0;
            skips_reg    <= FRAME_FULL;
            drive_reg    <= 1'b0;
            led_reg      <= 1'b0;
            led_cnt_reg  <= '0;
            wc_reg       <= '0;
            mte_reg      <= '0;
            freq_reg     <= '0;
        end else begin
            // Latch the sample and find the falling pin edge
            if (cmd.capture) begin
                prev_pin_reg <= zero_pin;
                crossing_reg <= prev_pin_reg & ~zero_pin;
                tick_reg     <= ms_tick;
            end
            // Drop the gate, count the crossing, advance the frame
            if (cmd.cross_step) begin
                drive_reg <= 1'b0;
                fp_reg    <= fp_next;
                if (wc_reg != '1) begin
                    wc_reg      <= wc_reg + 1'b1;
                    led_cnt_reg <= led_cnt_next;
                    if (led_cnt_reg == LED_LAST) begin
                        led_reg <= ~led_reg;
                    end
                end
            end
            // Load a new frame's fire and skip budget
            if (cmd.tgt_load) begin
                fires_reg <= tgt_next;
                skips_reg <= FRAME_FULL - tgt_next;
            end
            // Skip or fire this crossing
            if (cmd.frame_step) begin
                if (skips_reg > fires_reg) begin
                    skips_reg <= skips_reg - 1'b1;
                end else begin
                    if (fires_reg != '0) begin
                        fires_reg <= fires_reg - 1'b1;
                    end
                    if (heater_en_reg) begin
                        drive_reg <= 1'b1;
                    end
                end
            end
            // Count down the window, or close it with a new frequency
            if (cmd.window_dec) begin
                mte_reg <= mte_reg - 1'b1;
            end
            if (cmd.freq_load) begin
                freq_reg    <= freq_next;
                wc_reg      <= '0;
                led_cnt_reg <= '0;
                mte_reg     <= period_eff - 1'b1;
            end
        end
    end

    // Output register: hold until taken, reload when free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {{(bfzc_pkg::M_TDATA_W - bfzc_pkg::M_FIELDS_W){1'b0}},
                            wc_reg, freq_reg, crossing_reg, led_reg, drive_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Status to the controller
    always_comb begin
        sts.crossing   = crossing_reg;
        sts.tick       = tick_reg;
        sts.frame_wrap = (fp_reg == FRAME_LAST);
        sts.window_end = (mte_reg == '0);
        sts.div_done   = div_done;
        sts.out_free   = ~m_tvalid_reg | m_tready;
    end

endmodule

@@ src/bfzc_ctrl.sv @@
// Controller state machine: sequences one item through crossing handling,
// frame budget, window end and result load. Depends on bfzc_pkg.
module bfzc_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  bfzc_pkg::bfzc_sts_t     sts,
    output bfzc_pkg::bfzc_cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CROSS,
        S_FRAME,
        S_TICK,
        S_FREQ_WAIT,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_CROSS;
                end
            end
            S_CROSS: begin
                if (!sts.crossing) begin
                    state_next = S_TICK;
                end else begin
                    cmd.cross_step = 1'b1;
                    cmd.tgt_load   = sts.frame_wrap;
                    state_next     = S_FRAME;
                end
            end
            S_FRAME: begin
                cmd.frame_step = 1'b1;
                state_next     = S_TICK;
            end
            S_TICK: begin
                if (!sts.tick) begin
                    state_next = S_DONE;
                end else if (sts.window_end) begin
                    cmd.freq_start = 1'b1;
                    state_next     = S_FREQ_WAIT;
                end else begin
                    cmd.window_dec = 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_FREQ_WAIT: begin
                if (sts.div_done) begin
                    cmd.freq_load = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/burst_fire_zero_cross_power_control_top.sv @@
// Channel   Dir  Bits  Contents
// s_        in   8     zero_pin, ms_tick (lowest bit up)
// m_        out  32    heater_drive, led_level, crossing_seen, mains_freq, crossings_counted
// cfg_      in   2/16  register index and write data, one write per cycle with cfg_we
//
// One item at a time: each sample goes through capture, the crossing check, the frame budget
// (with a crossing only) and the tick check; when a tick closes the measurement window, the
// 26-step one-bit-per-cycle divider computes crossings*1000/period and its result is loaded.
// A finished result waits in the output register while the next beat is accepted;
// a stalled m_ side stops the block only at the load of the following result.
// Reset is synchronous and active low.
//
// Top level of the burst-fire power controller. Depends on bfzc_pkg,
// bfzc_ctrl, bfzc_dp and bfzc_div.
module burst_fire_zero_cross_power_control_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input beats
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bfzc_pkg::S_TDATA_W-1:0]      s_tdata,   // zero_pin, ms_tick
    // result beats
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // heater_drive, led_level, crossing_seen, mains_freq[9:0], crossings_counted[15:0]
    output logic [bfzc_pkg::M_TDATA_W-1:0]      m_tdata,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [bfzc_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [bfzc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    bfzc_pkg::bfzc_cmd_t cmd;
    bfzc_pkg::bfzc_sts_t sts;

    bfzc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bfzc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .zero_pin  (s_tdata[0]),
        .ms_tick   (s_tdata[1]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

@@ src/bfzc_checker.sv @@
// Port-level checker for the burst-fire power controller, bound to the top.
// Depends on bfzc_pkg and the assertion macro header.
`include "burst_fire_zero_cross_power_control_top_defines.svh"

module bfzc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [bfzc_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                             cfg_we
);

    // A stalled result beat keeps its payload
    `BFZC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // An accepted beat puts the block to work: no second beat on the next edge
    `BFZC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input accepted twice in a row")

    // A new result appears only after the item's work, never while idle
    `BFZC_ASSERT_NOW(a_result_from_work, $rose(m_tvalid), $past(!s_tready), "result appeared without a finished item")

    // Register writes must land only while no item is being worked on; the block itself does not enforce it
    `BFZC_ASSERT_NOW(a_cfg_idle, cfg_we, s_tready, "register written while an item was in flight")

endmodule

bind burst_fire_zero_cross_power_control_top bfzc_checker u_bfzc_checker (.*);
